FILE: rtl/pee_pkg.sv
// Shared types and codes for the prefix expression evaluator.
package pee_pkg;

   // Operator codes as stored on the pending stack
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // Input token kinds
   localparam logic [2:0] CMD_OPERAND = 3'd0;
   localparam logic [2:0] CMD_ADD     = 3'd1;
   localparam logic [2:0] CMD_DIV     = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DIV0 = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;
   localparam logic [1:0] STATUS_OPEN = 2'd3;

   // Token classes after decode
   localparam logic [1:0] KIND_OPERAND  = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_IGNORE   = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [29:0] operand_value;
      logic        last_token;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_payload_type;

   // Decoded token between front and back
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  op;
      logic [29:0] value;
      logic        last;
   } token_type;

   // One pending operator
   typedef struct packed {
      logic [1:0]  op;
      logic        have_first;
      logic [31:0] first;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/pee_front.sv
// Front stage: accepts requests and decodes them into tokens.
module pee_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pee_pkg::req_payload_type req_data,
   output logic                     tok_valid,
   input  logic                     tok_ready,
   output pee_pkg::token_type       tok_data
);

   logic               valid_ff, valid_in;
   pee_pkg::token_type tok_ff, tok_in;

   assign req_ready = !valid_ff || tok_ready;
   assign tok_valid = valid_ff;
   assign tok_data  = tok_ff;

   // Decode the token kind and operator code
   always_comb begin
      tok_in       = tok_ff;
      tok_in.value = req_data.operand_value;
      tok_in.last  = req_data.last_token;
      tok_in.op    = 2'(req_data.cmd - pee_pkg::CMD_ADD);
      if (req_data.cmd == pee_pkg::CMD_OPERAND) begin
         tok_in.kind = pee_pkg::KIND_OPERAND;
      end else if (req_data.cmd <= pee_pkg::CMD_DIV) begin
         tok_in.kind = pee_pkg::KIND_OPERATOR;
      end else begin
         tok_in.kind = pee_pkg::KIND_IGNORE;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (tok_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         tok_ff <= tok_in;
      end
   end

endmodule

FILE: rtl/pee_queue.sv
// Short token queue between the front and back stages.
module pee_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pee_pkg::token_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pee_pkg::token_type out_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pee_pkg::token_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/pee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module pee_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pee_pkg::div_cmd_type div_cmd,
   output pee_pkg::div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   // Load magnitudes on start, then one restoring step per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      if (div_cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = div_cmd.dividend[31] ? (32'd0 - div_cmd.dividend) : div_cmd.dividend;
         dvs_in   = div_cmd.divisor[31] ? (32'd0 - div_cmd.divisor) : div_cmd.divisor;
         neg_in   = div_cmd.dividend[31] ^ div_cmd.divisor[31];
      end else if (busy_ff) begin
         rem_in   = fits ? diff[31:0] : trial[31:0];
         quo_in   = {quo_ff[30:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_ff   <= neg_in;
   end

endmodule

FILE: rtl/pee_back.sv
// Back stage: pending-operator stack, arithmetic sequencer and result register.
module pee_back #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tok_valid,
   output logic                     tok_ready,
   input  pee_pkg::token_type       tok_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pee_pkg::rsp_payload_type rsp_data
);

   localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
   localparam int MEM_DEPTH = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1;
   localparam int MIDX_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_DIVW = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   // Entries below the top; the top entry lives in top_ff
   pee_pkg::entry_type mem [MEM_DEPTH];

   logic [2:0]               state_ff, state_in;
   logic [LVL_W-1:0]         level_ff, level_in;
   pee_pkg::entry_type       top_ff, top_in;
   logic [31:0]              v_ff, v_in;
   logic                     last_ff, last_in;
   pee_pkg::rsp_payload_type res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pee_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   pee_pkg::entry_type       rd_data_ff;

   logic                     mem_we, mem_re;
   logic [MIDX_W-1:0]        mem_waddr, mem_raddr;
   logic [LVL_W-1:0]         lvl_m1, lvl_m2;
   logic                     stack_full;
   pee_pkg::div_cmd_type     div_cmd;
   pee_pkg::div_rsp_type     div_rsp;

   assign lvl_m1     = level_ff - LVL_W'(1);
   assign lvl_m2     = level_ff - LVL_W'(2);
   assign mem_waddr  = lvl_m1[MIDX_W-1:0];
   assign mem_raddr  = lvl_m2[MIDX_W-1:0];
   assign stack_full = (level_ff == LVL_W'(STACK_DEPTH));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   pee_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   // Sequencer: take a token, then collapse operators one at a time
   always_comb begin
      state_in          = state_ff;
      level_in          = level_ff;
      top_in            = top_ff;
      v_in              = v_ff;
      last_in           = last_ff;
      res_in            = res_ff;
      tok_ready         = 1'b0;
      mem_we            = 1'b0;
      mem_re            = 1'b0;
      div_cmd.start     = 1'b0;
      div_cmd.dividend  = top_ff.first;
      div_cmd.divisor   = v_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            tok_ready = 1'b1;
            if (tok_valid) begin
               last_in = tok_data.last;
               unique case (tok_data.kind)
                  pee_pkg::KIND_OPERATOR: begin
                     if (stack_full) begin
                        res_in   = '{result_value: '0, status: pee_pkg::STATUS_OVF};
                        level_in = '0;
                        state_in = S_EMIT;
                     end else begin
                        mem_we   = (level_ff != '0);
                        top_in   = '{op: tok_data.op, have_first: 1'b0, first: '0};
                        level_in = level_ff + LVL_W'(1);
                        if (tok_data.last) begin
                           res_in   = '{result_value: '0, status: pee_pkg::STATUS_OPEN};
                           level_in = '0;
                           state_in = S_EMIT;
                        end
                     end
                  end
                  pee_pkg::KIND_OPERAND: begin
                     v_in     = {2'b00, tok_data.value};
                     state_in = S_EVAL;
                  end
                  default: begin
                     if (tok_data.last && level_ff != '0) begin
                        res_in   = '{result_value: '0, status: pee_pkg::STATUS_OPEN};
                        level_in = '0;
                        state_in = S_EMIT;
                     end
                  end
               endcase
            end
         end

         S_EVAL: begin
            priority if (level_ff == '0) begin
               res_in   = '{result_value: v_ff, status: pee_pkg::STATUS_OK};
               state_in = S_EMIT;
            end else if (!top_ff.have_first) begin
               top_in.have_first = 1'b1;
               top_in.first      = v_ff;
               if (last_ff) begin
                  res_in   = '{result_value: '0, status: pee_pkg::STATUS_OPEN};
                  level_in = '0;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (top_ff.op == pee_pkg::OP_DIV) begin
               if (v_ff == '0) begin
                  res_in   = '{result_value: '0, status: pee_pkg::STATUS_DIV0};
                  level_in = '0;
                  state_in = S_EMIT;
               end else begin
                  div_cmd.start = 1'b1;
                  state_in      = S_DIVW;
               end
            end else begin
               unique case (top_ff.op)
                  pee_pkg::OP_ADD: v_in = top_ff.first + v_ff;
                  pee_pkg::OP_SUB: v_in = top_ff.first - v_ff;
                  default:         v_in = 32'(top_ff.first * v_ff);
               endcase
               state_in = S_POP;
            end
         end

         S_DIVW: begin
            if (div_rsp.done) begin
               v_in     = div_rsp.quotient;
               state_in = S_POP;
            end
         end

         S_POP: begin
            level_in = lvl_m1;
            if (level_ff > LVL_W'(1)) begin
               mem_re   = 1'b1;
               state_in = S_FILL;
            end else begin
               state_in = S_EVAL;
            end
         end

         S_FILL: begin
            top_in   = rd_data_ff;
            state_in = S_EVAL;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Stack memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= top_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff      <= top_in;
      v_ff        <= v_in;
      last_ff     <= last_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/prefix_expression_evaluator_unit.sv
// Top level of the prefix expression evaluator: front, token queue and back.
//
// Evaluates prefix-notation token streams with 32-bit wrapping arithmetic.
// Requests are decoded by a front register and parked in a four-entry token
// queue, so the input keeps flowing while the back stage works. The back stage
// handles one token at a time: an operator or an ignored token is taken in
// the idle state; an operand goes to evaluation and, for every pending
// operator it completes, through a combine or a divide, a pop and a fill
// of the new top from memory. The iterative divider produces one quotient
// bit per cycle. The operator at the bottom of the stack needs no fill, as
// no memory read follows its pop. A token that ends in a result passes
// through the emit state to load the result register, which then holds the
// result until it is taken. Stack entries live in a memory of STACK_DEPTH-1
// words plus a top register. Errors (divide by zero, overflow, open
// expression) return status with a zero value and empty the stack.
module prefix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pee_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pee_pkg::rsp_payload_type rsp_data
);

   logic               fq_valid, fq_ready;
   pee_pkg::token_type fq_data;
   logic               qb_valid, qb_ready;
   pee_pkg::token_type qb_data;

   pee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tok_valid (fq_valid),
      .tok_ready (fq_ready),
      .tok_data  (fq_data)
   );

   pee_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   pee_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (qb_valid),
      .tok_ready (qb_ready),
      .tok_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/pee_checker.sv
// Port-level checks for the prefix expression evaluator, bound to the top level.
module pee_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input pee_pkg::rsp_payload_type rsp_data
);

   // A result stalled by the consumer stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // Error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pee_pkg::STATUS_OK |-> rsp_data.result_value == '0)
      else $error("error result with nonzero value");

   // Reset leaves no result offered and the input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // The input ready is never unknown outside reset
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req_ready))
      else $error("req_ready unknown");

endmodule

bind prefix_expression_evaluator_unit pee_checker u_checker (.*);

FILE: tb/prefix_expression_evaluator_unit_tb.sv
// Self-checking testbench for the prefix expression evaluator: token streams in, values out.
`timescale 1ns / 100ps

module prefix_expression_evaluator_unit_tb;

   localparam int STACK_LIMIT    = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 3000;
   localparam int HOLD_CYCLES    = 600;
   localparam int ITEMS_PER_PHASE = 425;

   // Token kinds not named in the package
   localparam logic [2:0] CMD_SUB_TOKEN = 3'd2;
   localparam logic [2:0] CMD_MUL_TOKEN = 3'd3;
   localparam logic [2:0] CMD_SPARE_0   = 3'd5;
   localparam logic [2:0] CMD_SPARE_1   = 3'd6;
   localparam logic [2:0] CMD_SPARE_2   = 3'd7;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   pee_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   pee_pkg::rsp_payload_type rsp_data;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_cycles = 0;
   int items_sent  = 0;
   int quiet_count = 0;
   pee_pkg::req_payload_type token_batch[$];

   // Shadow evaluator plus the queue of values it still owes
   class expr_scoreboard;
      logic [1:0]               pend_op[STACK_LIMIT];
      bit                       pend_has_first[STACK_LIMIT];
      logic [31:0]              pend_first[STACK_LIMIT];
      int                       pend_count;
      pee_pkg::rsp_payload_type expected_results[$];
      int                       errors;

      function new();
         pend_count = 0;
         errors     = 0;
      endfunction

      // 32-bit wrapping arithmetic, division truncating toward zero
      function logic [31:0] combine(logic [1:0] op, logic [31:0] a, logic [31:0] b);
         logic [31:0] mag_a, mag_b, quot;
         case (op)
            pee_pkg::OP_ADD: return a + b;
            pee_pkg::OP_SUB: return a - b;
            pee_pkg::OP_MUL: return a * b;
            default: begin
               mag_a = a[31] ? 32'd0 - a : a;
               mag_b = b[31] ? 32'd0 - b : b;
               quot  = mag_a / mag_b;
               return (a[31] ^ b[31]) ? 32'd0 - quot : quot;
            end
         endcase
      endfunction

      function bit fail_with(logic [1:0] code, output pee_pkg::rsp_payload_type res);
         pend_count        = 0;
         res.result_value  = '0;
         res.status        = code;
         return 1'b1;
      endfunction

      // Returns 1 when the token yields a result
      function bit evaluate_token(pee_pkg::req_payload_type tok,
                                  output pee_pkg::rsp_payload_type res);
         logic [31:0] v;
         logic [1:0]  top_op;
         v   = {2'b00, tok.operand_value};
         res = '0;
         if (tok.cmd >= pee_pkg::CMD_ADD && tok.cmd <= pee_pkg::CMD_DIV) begin
            if (pend_count >= STACK_LIMIT) return fail_with(pee_pkg::STATUS_OVF, res);
            pend_op[pend_count]        = 2'(tok.cmd - pee_pkg::CMD_ADD);
            pend_has_first[pend_count] = 1'b0;
            pend_first[pend_count]     = '0;
            pend_count++;
         end else if (tok.cmd == pee_pkg::CMD_OPERAND) begin
            // a completed operator feeds its value to the one below
            forever begin
               if (pend_count == 0) begin
                  res.result_value = v;
                  res.status       = pee_pkg::STATUS_OK;
                  return 1'b1;
               end
               if (!pend_has_first[pend_count-1]) begin
                  pend_has_first[pend_count-1] = 1'b1;
                  pend_first[pend_count-1]     = v;
                  break;
               end
               top_op = pend_op[pend_count-1];
               if (top_op == pee_pkg::OP_DIV && v == 0)
                  return fail_with(pee_pkg::STATUS_DIV0, res);
               v = combine(top_op, pend_first[pend_count-1], v);
               pend_count--;
            end
         end
         if (tok.last_token && pend_count != 0) return fail_with(pee_pkg::STATUS_OPEN, res);
         return 1'b0;
      endfunction

      function void note_request(pee_pkg::req_payload_type tok);
         pee_pkg::rsp_payload_type res;
         if (evaluate_token(tok, res)) expected_results.push_back(res);
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(pee_pkg::rsp_payload_type got);
         pee_pkg::rsp_payload_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result value %0d status %0d",
                             $signed(got.result_value), got.status));
            return;
         end
         want = expected_results.pop_front();
         if (got.result_value !== want.result_value)
            report($sformatf("result value %0d, expected %0d",
                             $signed(got.result_value), $signed(want.result_value)));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endtask
   endclass

   expr_scoreboard sb;

   prefix_expression_evaluator_unit #(.STACK_DEPTH(STACK_LIMIT)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: long hold-off first, then random stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Check each result taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
         if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("[prefix_expression_evaluator_unit] ERROR");
            $finish;
         end
      end
   end

   function automatic pee_pkg::req_payload_type make_token(logic [2:0] cmd,
                                                           logic [29:0] value,
                                                           logic last);
      pee_pkg::req_payload_type t;
      t.cmd           = cmd;
      t.operand_value = value;
      t.last_token    = last;
      return t;
   endfunction

   function automatic logic [29:0] random_operand();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5)  return '0;
      if (pick < 40) return 30'($urandom_range(1, 9));
      if (pick < 60) return 30'($urandom_range(1, 1000));
      if (pick < 70) return 30'h3FFF_FFFF;
      if (pick < 75) return 30'd999999999;
      return 30'($urandom());
   endfunction

   function automatic pee_pkg::req_payload_type random_operator();
      return make_token(3'($urandom_range(pee_pkg::CMD_ADD, pee_pkg::CMD_DIV)),
                        30'($urandom()), 1'b0);
   endfunction

   // Well-formed prefix expression with up to n_ops operators
   function automatic void append_expression(int n_ops, int op_pct);
      int needed, ops_left;
      needed   = 1;
      ops_left = n_ops;
      while (needed > 0) begin
         if (ops_left > 0 && (needed == 1 || $urandom_range(99) < op_pct)) begin
            token_batch.push_back(random_operator());
            ops_left--;
            needed++;
         end else begin
            token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, random_operand(), 1'b0));
            needed--;
         end
      end
   endfunction

   function automatic void append_random_sequence();
      int pick, n, cut;
      pick = $urandom_range(99);
      if (pick < 68) begin
         append_expression($urandom_range(0, 6), $urandom_range(20, 70));
         if ($urandom_range(99) < 15) token_batch[token_batch.size()-1].last_token = 1'b1;
      end else if (pick < 80) begin
         // stream ends inside an expression
         append_expression($urandom_range(1, 6), 50);
         cut = $urandom_range(1, token_batch.size() - 1);
         repeat (cut) void'(token_batch.pop_back());
         token_batch[token_batch.size()-1].last_token = 1'b1;
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 6))
            token_batch.push_back(make_token(3'($urandom_range(0, 7)), 30'($urandom()),
                                             ($urandom_range(99) < 10)));
      end else if (pick < 97) begin
         append_expression($urandom_range(10, 63), $urandom_range(60, 95));
      end else begin
         // operator run around the stack size, then operands to close it
         n = $urandom_range(STACK_LIMIT - 4, STACK_LIMIT + 6);
         repeat (n) token_batch.push_back(random_operator());
         repeat (n + 1)
            token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, random_operand(), 1'b0));
      end
   endfunction

   // Drive one request; returns at the falling edge after acceptance
   task automatic send_request(pee_pkg::req_payload_type tok);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = tok;
      do @(posedge clock); while (!req_ready);
      sb.note_request(tok);
      if (tok.cmd <= pee_pkg::CMD_DIV) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_batch();
      foreach (token_batch[i]) send_request(token_batch[i]);
      token_batch.delete();
   endtask

   initial begin
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      hold_cycles = HOLD_CYCLES;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, each operator, error cases
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'h3FFF_FFFF, 1'b0));
      // most negative divided by minus one wraps
      token_batch.push_back(make_token(pee_pkg::CMD_DIV, 30'h3FFF_FFFF, 1'b0));
      token_batch.push_back(make_token(CMD_SUB_TOKEN, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, '0, 1'b0));
      token_batch.push_back(make_token(CMD_MUL_TOKEN, 30'h3FFF_FFFF, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd65536, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd32768, 1'b0));
      token_batch.push_back(make_token(CMD_SUB_TOKEN, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd1, 1'b0));
      // -7 / 2 truncates toward zero
      token_batch.push_back(make_token(pee_pkg::CMD_DIV, '0, 1'b0));
      token_batch.push_back(make_token(CMD_SUB_TOKEN, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd7, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd2, 1'b0));
      // divide by zero on the final token: only the error comes out
      token_batch.push_back(make_token(pee_pkg::CMD_DIV, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd7, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, '0, 1'b1));
      // ignored kinds, the last one ending an open expression
      token_batch.push_back(make_token(pee_pkg::CMD_ADD, '0, 1'b0));
      token_batch.push_back(make_token(pee_pkg::CMD_OPERAND, 30'd5, 1'b0));
      token_batch.push_back(make_token(CMD_SPARE_1, 30'h3FFF_FFFF, 1'b0));
      token_batch.push_back(make_token(CMD_SPARE_2, '0, 1'b0));
      token_batch.push_back(make_token(CMD_SPARE_0, 30'h1555_5555, 1'b1));
      send_batch();

      // Random traffic under four idling mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
            append_random_sequence();
            send_batch();
         end
      end
      req_valid = 1'b0;

      // Drain, then give any late result a chance to show up
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
         $display("[prefix_expression_evaluator_unit] OK");
      end else begin
         $display("[prefix_expression_evaluator_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/pee_pkg.sv
rtl/pee_front.sv
rtl/pee_queue.sv
rtl/pee_div.sv
rtl/pee_back.sv
rtl/prefix_expression_evaluator_unit.sv
rtl/pee_checker.sv
tb/prefix_expression_evaluator_unit_tb.sv
